// File: hdl/dms_pkg.sv
// shared types, constants and helpers for the markov sequence scorer
`timescale 1ns / 1ps

package dms_pkg;

	localparam int MAX_ORDER  = 5;
	localparam int SCORE_BITS = 24;
	localparam int ORDER_W    = 3;
	localparam int SEEN_W     = $clog2(MAX_ORDER + 1);
	localparam int INIT_AW    = 2 * MAX_ORDER;
	localparam int TRANS_AW   = INIT_AW + 2;
	localparam int INIT_DEPTH = 1 << INIT_AW;
	localparam int TRANS_DEPTH = 1 << TRANS_AW;
	localparam int IDX_W      = 12;
	localparam int COST_W     = 16;
	localparam int FUNC_W     = 2;
	localparam int CODE_W     = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [FUNC_W-1:0] FUNC_WR_INIT  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WR_TRANS = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SCORE    = 2'd2;

	typedef enum logic [1:0] {
		OP_WR_INIT  = 2'd0,
		OP_WR_TRANS = 2'd1,
		OP_SCORE    = 2'd2
	} dms_kind_t;

	typedef struct packed {
		dms_kind_t             kind;
		logic [TRANS_AW-1:0]   addr;
		logic [COST_W-1:0]     cost;
		logic                  first;
		logic                  last;
		logic                  invalid;
		logic                  add_cost;
		logic                  use_trans;
		logic                  too_short;
	} dms_op_t;

	// low 2*k bits set
	function automatic logic [INIT_AW-1:0] kmer_mask(input logic [SEEN_W-1:0] k);
		logic [INIT_AW-1:0] m;
		m = '0;
		for (int i = 0; i < MAX_ORDER; i++) begin
			m[2*i +: 2] = (SEEN_W'(i) < k) ? 2'b11 : 2'b00;
		end
		return m;
	endfunction

endpackage

// File: hdl/dms_fifo.sv
// short op queue between front and back
`timescale 1ns / 1ps

module dms_fifo
	import dms_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  dms_op_t push_op,
	input  logic    pop,
	output dms_op_t head_op,
	output logic    not_empty,
	output logic    full
);

	dms_op_t              slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;

	assign head_op   = slot_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue count overrun");

endmodule

// File: hdl/dms_front.sv
// front end: accepts requests, tracks k-mer context, forms table ops
`timescale 1ns / 1ps

module dms_front
	import dms_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ORDER_W-1:0]  cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [FUNC_W-1:0]   func,
	input  logic [IDX_W-1:0]    table_index,
	input  logic [COST_W-1:0]   cost_value,
	input  logic [CODE_W-1:0]   base_code,
	input  logic                first_base,
	input  logic                last_base,
	input  logic                q_full,
	output logic                q_push,
	output dms_op_t             q_op
);

	logic [ORDER_W-1:0] model_order_q;
	logic [INIT_AW-1:0] recent_q;
	logic [SEEN_W-1:0]  seen_q;

	logic               accept;
	logic               push_ok;
	logic [SEEN_W-1:0]  k;
	logic [SEEN_W-1:0]  seen0;
	logic [SEEN_W-1:0]  seen_next;
	logic [INIT_AW-1:0] recent0;
	logic [INIT_AW-1:0] shifted;
	logic [INIT_AW-1:0] recent_next;
	logic [INIT_AW-1:0] kmask;
	logic [1:0]         base;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;
	assign q_push    = accept && push_ok;

	always_comb begin
		k       = (model_order_q > ORDER_W'(MAX_ORDER)) ? SEEN_W'(MAX_ORDER)
		                                               : SEEN_W'(model_order_q);
		seen0   = first_base ? '0 : seen_q;
		recent0 = first_base ? '0 : recent_q;
		base    = base_code[1:0];
		shifted = {recent0[INIT_AW-3:0], base};
		kmask   = kmer_mask(k);

		recent_next = recent_q;
		seen_next   = seen_q;
		push_ok     = 1'b0;

		q_op           = '0;
		q_op.cost      = cost_value;
		q_op.first     = first_base;
		q_op.last      = last_base;
		q_op.invalid   = (base_code > CODE_W'(3));

		unique case (func)
			FUNC_WR_INIT: begin
				q_op.kind = OP_WR_INIT;
				q_op.addr = TRANS_AW'(table_index);
				push_ok   = ((table_index >> INIT_AW) == '0);
			end
			FUNC_WR_TRANS: begin
				q_op.kind = OP_WR_TRANS;
				q_op.addr = TRANS_AW'(table_index);
				push_ok   = ((table_index >> TRANS_AW) == '0);
			end
			FUNC_SCORE: begin
				q_op.kind   = OP_SCORE;
				push_ok     = 1'b1;
				recent_next = recent0;
				seen_next   = seen0;
				priority if (k == '0) begin
					// order 0: every base costs its own initial entry
					q_op.add_cost = 1'b1;
					q_op.addr     = TRANS_AW'(base);
				end else if (seen0 < k) begin
					// still filling the first k-mer
					recent_next   = shifted;
					seen_next     = seen0 + 1'b1;
					q_op.add_cost = (seen_next == k);
					q_op.addr     = TRANS_AW'(shifted & kmask);
				end else begin
					recent_next    = shifted;
					q_op.add_cost  = 1'b1;
					q_op.use_trans = 1'b1;
					q_op.addr      = {recent0 & kmask, base};
				end
				q_op.too_short = (k != '0) && (seen_next < k);
			end
			default: begin
				push_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_order_q <= '0;
			recent_q      <= '0;
			seen_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				model_order_q <= cfg_data;
			end
			if (accept && func == FUNC_SCORE) begin
				recent_q <= recent_next;
				seen_q   <= seen_next;
			end
		end
	end

endmodule

// File: hdl/dms_back.sv
// back end: cost tables, score accumulation and result register
`timescale 1ns / 1ps

module dms_back
	import dms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_not_empty,
	input  dms_op_t               q_head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SCORE_BITS-1:0] score,
	output logic                  zero_probability,
	output logic                  too_short
);

	logic [COST_W-1:0] init_mem  [INIT_DEPTH];
	logic [COST_W-1:0] trans_mem [TRANS_DEPTH];

	logic              s1_valid_q;
	dms_op_t           op_s1;
	logic [COST_W-1:0] init_rd_s1;
	logic [COST_W-1:0] trans_rd_s1;

	logic [SCORE_BITS-1:0] sum_q;
	logic                  inv_q;
	logic                  out_valid_q;
	logic [SCORE_BITS-1:0] score_q;
	logic                  zero_q;
	logic                  short_q;

	logic                  s1_adv;
	logic                  pop_score;
	logic [COST_W-1:0]     cost_sel;
	logic [SCORE_BITS-1:0] sum_base;
	logic [SCORE_BITS:0]   sum_wide;
	logic [SCORE_BITS-1:0] sum_next;
	logic                  inv_next;

	assign s1_adv    = s1_valid_q && (!op_s1.last || !out_valid_q || !out_stall);
	assign q_pop     = q_not_empty && (!s1_valid_q || s1_adv);
	assign pop_score = q_pop && (q_head.kind == OP_SCORE);

	// table port: one write or one read per popped op
	always_ff @(posedge clk) begin
		if (q_pop && q_head.kind == OP_WR_INIT) begin
			init_mem[q_head.addr[INIT_AW-1:0]] <= q_head.cost;
		end
		if (pop_score) begin
			init_rd_s1 <= init_mem[q_head.addr[INIT_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.kind == OP_WR_TRANS) begin
			trans_mem[q_head.addr] <= q_head.cost;
		end
		if (pop_score) begin
			trans_rd_s1 <= trans_mem[q_head.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop_score) begin
			op_s1 <= q_head;
		end
	end

	always_comb begin
		cost_sel = op_s1.use_trans ? trans_rd_s1 : init_rd_s1;
		sum_base = op_s1.first ? '0 : sum_q;
		sum_wide = {1'b0, sum_base} + (SCORE_BITS+1)'(cost_sel);
		if (!op_s1.add_cost) begin
			sum_next = sum_base;
		end else if (sum_wide[SCORE_BITS]) begin
			sum_next = '1;
		end else begin
			sum_next = sum_wide[SCORE_BITS-1:0];
		end
		inv_next = (op_s1.first ? 1'b0 : inv_q) | op_s1.invalid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			sum_q       <= '0;
			inv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				s1_valid_q <= pop_score;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				sum_q <= sum_next;
				inv_q <= inv_next;
			end
			if (s1_adv && op_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && op_s1.last) begin
			score_q <= inv_next ? '1 : sum_next;
			zero_q  <= inv_next;
			short_q <= op_s1.too_short;
		end
	end

	assign out_valid        = out_valid_q;
	assign score            = score_q;
	assign zero_probability = zero_q;
	assign too_short        = short_q;

	a_zero_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && zero_q |-> score_q == '1) else $error("invalid base not saturated");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(score_q))
		else $error("stalled result lost");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(s1_adv && op_s1.last))
		else $error("result overwritten while stalled");

endmodule

// File: hdl/dna_markov_sequence_score.sv
// top level of the dna markov sequence scorer
`timescale 1ns / 1ps

// Scores DNA sequences against a background Markov model held as -log2 costs.
// Input channel (in_valid / in_stall): one request per accepted edge; func 0
// and 1 load the initial and transition cost tables, func 2 scores one base,
// func 3 and out-of-range table writes are dropped.
// Config channel (cfg_valid / cfg_ready): writes model_order; ready is always
// high, write it only while no sequence is in flight.
// Output channel (out_valid / out_stall): one result per base marked last,
// carrying the saturated Q16.8 score, zero_probability and too_short.
// Throughput: one request per cycle while in_stall is low; each table has one
// port, used for either the write of a load request or the read of a scored base.
// Path: a last base passes the queue write at acceptance, the table read and the
// accumulate into the result register before its result shows.
// Reset clears the order, the k-mer context, the running sum and the handshake
// state; cost tables are not cleared and must be loaded before use.
// A stalled result holds on the outputs; the four-entry queue keeps taking
// requests until it fills, then in_stall rises.
module dna_markov_sequence_score
	import dms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [ORDER_W-1:0]    cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [FUNC_W-1:0]     func,
	input  logic [IDX_W-1:0]      table_index,
	input  logic [COST_W-1:0]     cost_value,
	input  logic [CODE_W-1:0]     base_code,
	input  logic                  first_base,
	input  logic                  last_base,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SCORE_BITS-1:0] score,
	output logic                  zero_probability,
	output logic                  too_short
);

	// front to queue
	logic    q_push;
	dms_op_t q_push_op;
	logic    q_full;

	// queue to back
	logic    q_pop;
	dms_op_t q_head;
	logic    q_not_empty;

	dms_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.table_index (table_index),
		.cost_value  (cost_value),
		.base_code   (base_code),
		.first_base  (first_base),
		.last_base   (last_base),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_op        (q_push_op)
	);

	// decouples base intake from table access and result stalls
	dms_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (q_push_op),
		.pop       (q_pop),
		.head_op   (q_head),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	dms_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_not_empty      (q_not_empty),
		.q_head           (q_head),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.score            (score),
		.zero_probability (zero_probability),
		.too_short        (too_short)
	);

endmodule
